FILE: rtl/segregated_fit_heap_allocator_unit_assert.svh
// Assertion macros for the heap allocator.
`ifndef SEGREGATED_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define SEGREGATED_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define SFHA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SFHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/sfha_pkg.sv
// ----------------------------------------------------------------------------
// sfha_pkg
// Types, constants and helper functions of the segregated-fit heap allocator.
// ----------------------------------------------------------------------------
package sfha_pkg;

   localparam int HEAP_WORDS       = 8192;
   localparam int HEAP_BYTES       = HEAP_WORDS * 8;
   localparam int SIZE_CLASSES     = 10;
   localparam int BASE_CLASS_BYTES = 32;
   localparam int TAG_BYTES        = 8;

   localparam int OFF_W   = $clog2(HEAP_BYTES) + 1;   // byte offset incl. heap end
   localparam int WADDR_W = $clog2(HEAP_WORDS);
   localparam int CLS_W   = $clog2(SIZE_CLASSES);
   localparam int WALK_W  = $clog2(HEAP_WORDS) + 1;
   localparam int TOT_W   = OFF_W + 1;

   localparam logic [OFF_W-1:0]  NULL_LINK  = '1;
   localparam logic [CLS_W-1:0]  LAST_CLASS = CLS_W'(SIZE_CLASSES - 1);
   localparam logic [WALK_W-1:0] WALK_LIMIT = WALK_W'(HEAP_WORDS);

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_NULL = 2'd1;
   localparam logic [1:0] STATUS_BAD  = 2'd2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic REG_ALIGN = 1'b0;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_A_LOAD,
      ST_FIT_CHECK,
      ST_FIT_HDR,
      ST_FIT_LINK,
      ST_POP_LINK,
      ST_POP_HDR,
      ST_PLACE,
      ST_GROW,
      ST_T_HDR,
      ST_T_FTR,
      ST_PUSH_CLS,
      ST_PUSH_WR,
      ST_F_RD,
      ST_F_CHK,
      ST_F_NCHK,
      ST_F_PREV,
      ST_F_PCHK,
      ST_F_PHDR,
      ST_U_LOAD,
      ST_U_CHECK,
      ST_U_LINK,
      ST_U_END,
      ST_F_TAG,
      ST_DONE
   } state_type;

   function automatic logic [CLS_W-1:0] class_for(input logic [TOT_W-1:0] bytes);
      logic [CLS_W-1:0] c;
      c = LAST_CLASS;
      for (int i = SIZE_CLASSES - 2; i >= 0; i--) begin
         if (bytes <= TOT_W'(BASE_CLASS_BYTES << i)) c = CLS_W'(i);
      end
      return c;
   endfunction

   function automatic logic [OFF_W-1:0] size_clamp(input logic [63:0] w);
      logic [63:0] s;
      s = w & ~64'd1;
      if (s > 64'(HEAP_BYTES)) return OFF_W'(HEAP_BYTES);
      return s[OFF_W-1:0];
   endfunction

   function automatic logic [OFF_W-1:0] next_of(input logic [63:0] w);
      if (w >= 64'(HEAP_BYTES)) return NULL_LINK;
      return w[OFF_W-1:0];
   endfunction

   function automatic logic [63:0] link_word(input logic [OFF_W-1:0] v);
      if (v == NULL_LINK) return '1;
      return {{(64-OFF_W){1'b0}}, v};
   endfunction

endpackage

FILE: rtl/segregated_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// segregated_fit_heap_allocator_unit
// Segregated free-list heap allocator with boundary tags over a 64-bit heap RAM.
// ----------------------------------------------------------------------------
// One command at a time: busy rises at the accepting edge and stays high
// through the result strobe cycle; it is low again in the cycle after it. The
// result is shown for one cycle on rsp_valid and cannot be held off. Run time
// depends on the data: every heap access goes through the single port of the
// heap RAM, one access per cycle. A zero request, a free of zero or a free
// rejected on its address goes straight to the strobe; a free rejected on its
// header first reads that header. An allocate walks the free list of its own
// class and of the last class for a first fit, skips empty classes and pops
// the head of any class between them, then writes the tags (grow included),
// writes the tags of the remainder and pushes it when it splits, and strobes;
// out of memory strobes after the last class. A free checks the tags, unlinks
// each neighbor merged by walking its list, then writes the tags, pushes the
// block and strobes. List walks stop after HEAP_WORDS nodes. No clearing pass:
// heap words are undefined until written.
module segregated_fit_heap_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [15:0] req_request_bytes,
   input  logic [15:0] req_payload_addr,
   output logic        rsp_valid,
   output logic [15:0] rsp_result_addr,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_grow_count,
   output logic [31:0] rsp_split_count,
   output logic [31:0] rsp_merge_count,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sfha_pkg::*;

   `include "segregated_fit_heap_allocator_unit_assert.svh"

   state_type st_ff, st_in;

   logic [63:0] heap_mem [HEAP_WORDS];
   logic [63:0] mem_q_ff;
   logic [OFF_W-1:0] mem_addr;
   logic             mem_we;
   logic [63:0]      mem_wd;

   logic [OFF_W-1:0] head_ff [SIZE_CLASSES];
   logic             head_we;
   logic [OFF_W-1:0] head_wd;
   logic [OFF_W-1:0] head_rd;

   logic [3:0]       align_ff;
   logic [OFF_W-1:0] brk_ff, brk_in;
   logic [31:0]      grows_ff, grows_in, splits_ff, splits_in, merges_ff, merges_in;

   logic [CLS_W-1:0]  cls_ff, cls_in;
   logic              first_ff, first_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [OFF_W-1:0]  cur_ff, cur_in, prev_ff, prev_in, h_ff, h_in, len_ff, len_in;
   logic [WALK_W-1:0] n_ff, n_in;
   logic [OFF_W-1:0]  tag_at_ff, tag_at_in, tag_sz_ff, tag_sz_in, left_ff, left_in;
   logic              tag_used_ff, tag_used_in, tag_push_ff, tag_push_in;
   logic              split_ff, split_in;
   logic [OFF_W-1:0]  hdr_ff, hdr_in, base_ff, base_in, size_ff, size_in;
   logic [OFF_W-1:0]  target_ff, target_in, add_ff, add_in;
   logic              phase_ff, phase_in, found_ff, found_in;
   logic [15:0]       res_ff, res_in;
   logic [1:0]        status_ff, status_in;

   logic [3:0]       lg;
   logic [OFF_W-1:0] a_bytes, a_mask, minb;
   logic [TOT_W-1:0] req_tot, req_rnd;
   logic [OFF_W-1:0] q_next, q_size;
   logic [63:0]      q_bare;
   logic [OFF_W-1:0] left_calc, fr_hdr;
   logic             cfg_wr;

   assign lg      = (align_ff < 4'd3) ? 4'd3 : ((align_ff > 4'd8) ? 4'd8 : align_ff);
   assign a_bytes = OFF_W'(1) << lg;
   assign a_mask  = a_bytes - OFF_W'(1);
   assign minb    = a_bytes + OFF_W'(16);
   assign req_tot = TOT_W'(req_request_bytes) + TOT_W'(a_bytes) + TOT_W'(TAG_BYTES)
                    + TOT_W'(a_mask);
   assign req_rnd = req_tot & ~TOT_W'(a_mask);
   assign q_next  = next_of(mem_q_ff);
   assign q_size  = size_clamp(mem_q_ff);
   assign q_bare  = mem_q_ff & ~64'd1;
   assign head_rd = head_ff[cls_ff];
   assign left_calc = (TOT_W'(len_ff) > total_ff) ? (len_ff - total_ff[OFF_W-1:0]) : '0;
   assign fr_hdr  = OFF_W'(req_payload_addr) - a_bytes;

   // next state and datapath
   always_comb begin
      st_in = st_ff;
      brk_in = brk_ff; grows_in = grows_ff; splits_in = splits_ff; merges_in = merges_ff;
      cls_in = cls_ff; first_in = first_ff; total_in = total_ff;
      cur_in = cur_ff; prev_in = prev_ff; h_in = h_ff; len_in = len_ff; n_in = n_ff;
      tag_at_in = tag_at_ff; tag_sz_in = tag_sz_ff; left_in = left_ff;
      tag_used_in = tag_used_ff; tag_push_in = tag_push_ff; split_in = split_ff;
      hdr_in = hdr_ff; base_in = base_ff; size_in = size_ff;
      target_in = target_ff; add_in = add_ff; phase_in = phase_ff; found_in = found_ff;
      res_in = res_ff; status_in = status_ff;
      mem_addr = '0; mem_we = 1'b0; mem_wd = '0;
      head_we = 1'b0; head_wd = '0;

      case (st_ff)
         ST_IDLE: begin
            if (start) begin
               res_in = '0;
               status_in = STATUS_OK;
               if (req_cmd == CMD_ALLOC) begin
                  total_in = (req_rnd < TOT_W'(minb)) ? TOT_W'(minb) : req_rnd;
                  cls_in   = class_for((req_rnd < TOT_W'(minb)) ? TOT_W'(minb) : req_rnd);
                  first_in = 1'b1;
                  if (req_request_bytes == 16'd0) begin
                     status_in = STATUS_NULL;
                     st_in = ST_DONE;
                  end else begin
                     st_in = ST_A_LOAD;
                  end
               end else begin
                  hdr_in = fr_hdr;
                  if (req_payload_addr == 16'd0) begin
                     st_in = ST_DONE;
                  end else if (OFF_W'(req_payload_addr) < a_bytes ||
                               (OFF_W'(req_payload_addr) & a_mask) != '0 ||
                               fr_hdr >= brk_ff) begin
                     status_in = STATUS_BAD;
                     st_in = ST_DONE;
                  end else begin
                     st_in = ST_F_RD;
                  end
               end
            end
         end
         ST_A_LOAD: begin
            if (first_ff || cls_ff == LAST_CLASS) begin
               cur_in = head_rd; prev_in = NULL_LINK; n_in = '0;
               st_in = ST_FIT_CHECK;
            end else if (head_rd == NULL_LINK) begin
               cls_in = cls_ff + CLS_W'(1);
            end else begin
               h_in = head_rd;
               mem_addr = head_rd + a_bytes;
               st_in = ST_POP_LINK;
            end
         end
         ST_POP_LINK: begin
            head_we = 1'b1; head_wd = q_next;
            mem_addr = h_ff;
            st_in = ST_POP_HDR;
         end
         ST_POP_HDR: begin
            len_in = q_size;
            st_in = ST_PLACE;
         end
         ST_FIT_CHECK: begin
            if (cur_ff == NULL_LINK || n_ff >= WALK_LIMIT) begin
               first_in = 1'b0;
               if (cls_ff == LAST_CLASS) begin
                  st_in = ST_GROW;
               end else begin
                  cls_in = cls_ff + CLS_W'(1);
                  st_in = ST_A_LOAD;
               end
            end else begin
               mem_addr = cur_ff;
               st_in = ST_FIT_HDR;
            end
         end
         ST_FIT_HDR: begin
            len_in = q_size;
            mem_addr = cur_ff + a_bytes;
            st_in = ST_FIT_LINK;
         end
         ST_FIT_LINK: begin
            if (total_ff <= TOT_W'(len_ff)) begin
               if (prev_ff == NULL_LINK) begin
                  head_we = 1'b1; head_wd = q_next;
               end else begin
                  mem_addr = prev_ff + a_bytes; mem_we = 1'b1; mem_wd = link_word(q_next);
               end
               h_in = cur_ff;
               st_in = ST_PLACE;
            end else begin
               prev_in = cur_ff; cur_in = q_next; n_in = n_ff + WALK_W'(1);
               st_in = ST_FIT_CHECK;
            end
         end
         ST_PLACE: begin
            left_in = left_calc;
            split_in = (left_calc >= minb);
            tag_at_in = h_ff;
            tag_sz_in = (left_calc >= minb) ? total_ff[OFF_W-1:0] : len_ff;
            tag_used_in = 1'b1; tag_push_in = 1'b0;
            if (left_calc >= minb) splits_in = splits_ff + 32'd1;
            res_in = 16'(h_ff + a_bytes);
            st_in = ST_T_HDR;
         end
         ST_GROW: begin
            if (total_ff > TOT_W'(OFF_W'(HEAP_BYTES) - brk_ff)) begin
               status_in = STATUS_NULL;
               st_in = ST_DONE;
            end else begin
               tag_at_in = brk_ff; tag_sz_in = total_ff[OFF_W-1:0];
               tag_used_in = 1'b1; tag_push_in = 1'b0; split_in = 1'b0;
               brk_in = brk_ff + total_ff[OFF_W-1:0];
               grows_in = grows_ff + 32'd1;
               res_in = 16'(brk_ff + a_bytes);
               st_in = ST_T_HDR;
            end
         end
         ST_T_HDR: begin
            mem_addr = tag_at_ff; mem_we = 1'b1;
            mem_wd = {{(64-OFF_W){1'b0}}, tag_sz_ff} | {63'd0, tag_used_ff};
            st_in = ST_T_FTR;
         end
         ST_T_FTR: begin
            mem_addr = tag_at_ff + tag_sz_ff - OFF_W'(TAG_BYTES); mem_we = 1'b1;
            mem_wd = {{(64-OFF_W){1'b0}}, tag_sz_ff};
            if (tag_push_ff) begin
               st_in = ST_PUSH_CLS;
            end else if (split_ff) begin
               tag_at_in = tag_at_ff + tag_sz_ff; tag_sz_in = left_ff;
               tag_used_in = 1'b0; tag_push_in = 1'b1; split_in = 1'b0;
               st_in = ST_T_HDR;
            end else begin
               st_in = ST_DONE;
            end
         end
         ST_PUSH_CLS: begin
            cls_in = class_for(TOT_W'(tag_sz_ff));
            st_in = ST_PUSH_WR;
         end
         ST_PUSH_WR: begin
            mem_addr = tag_at_ff + a_bytes; mem_we = 1'b1; mem_wd = link_word(head_rd);
            head_we = 1'b1; head_wd = tag_at_ff;
            st_in = ST_DONE;
         end
         ST_F_RD: begin
            mem_addr = hdr_ff;
            st_in = ST_F_CHK;
         end
         ST_F_CHK: begin
            size_in = q_bare[OFF_W-1:0];
            base_in = hdr_ff;
            target_in = hdr_ff + q_bare[OFF_W-1:0];
            mem_addr = hdr_ff + q_bare[OFF_W-1:0];
            if (!mem_q_ff[0] || q_bare < 64'(minb) || (q_bare[OFF_W-1:0] & a_mask) != '0 ||
                q_bare > 64'(brk_ff - hdr_ff)) begin
               status_in = STATUS_BAD;
               st_in = ST_DONE;
            end else if (hdr_ff + q_bare[OFF_W-1:0] < brk_ff) begin
               st_in = ST_F_NCHK;
            end else begin
               st_in = ST_F_PREV;
            end
         end
         ST_F_NCHK: begin
            if (!mem_q_ff[0] && q_bare != 64'd0 && q_bare <= 64'(brk_ff - target_ff)) begin
               add_in = q_bare[OFF_W-1:0];
               cls_in = class_for(TOT_W'(q_bare[OFF_W-1:0]));
               phase_in = 1'b0;
               st_in = ST_U_LOAD;
            end else begin
               st_in = ST_F_PREV;
            end
         end
         ST_F_PREV: begin
            mem_addr = hdr_ff - OFF_W'(TAG_BYTES);
            st_in = (hdr_ff == '0) ? ST_F_TAG : ST_F_PCHK;
         end
         ST_F_PCHK: begin
            target_in = hdr_ff - q_bare[OFF_W-1:0];
            add_in = q_bare[OFF_W-1:0];
            mem_addr = hdr_ff - q_bare[OFF_W-1:0];
            if (q_bare != 64'd0 && q_bare <= 64'(hdr_ff)) st_in = ST_F_PHDR;
            else st_in = ST_F_TAG;
         end
         ST_F_PHDR: begin
            if (!mem_q_ff[0]) begin
               cls_in = class_for(TOT_W'(q_size));
               phase_in = 1'b1;
               st_in = ST_U_LOAD;
            end else begin
               st_in = ST_F_TAG;
            end
         end
         ST_U_LOAD: begin
            cur_in = head_rd; prev_in = NULL_LINK; n_in = '0;
            st_in = ST_U_CHECK;
         end
         ST_U_CHECK: begin
            if (cur_ff == NULL_LINK || n_ff >= WALK_LIMIT) begin
               st_in = ST_U_END;
            end else begin
               mem_addr = cur_ff + a_bytes;
               found_in = (cur_ff == target_ff);
               st_in = ST_U_LINK;
            end
         end
         ST_U_LINK: begin
            if (found_ff) begin
               if (prev_ff == NULL_LINK) begin
                  head_we = 1'b1; head_wd = q_next;
               end else begin
                  mem_addr = prev_ff + a_bytes; mem_we = 1'b1; mem_wd = link_word(q_next);
               end
               st_in = ST_U_END;
            end else begin
               prev_in = cur_ff; cur_in = q_next; n_in = n_ff + WALK_W'(1);
               st_in = ST_U_CHECK;
            end
         end
         ST_U_END: begin
            size_in = size_ff + add_ff;
            merges_in = merges_ff + 32'd1;
            if (phase_ff) begin
               base_in = target_ff;
               st_in = ST_F_TAG;
            end else begin
               st_in = ST_F_PREV;
            end
         end
         ST_F_TAG: begin
            tag_at_in = base_ff; tag_sz_in = size_ff;
            tag_used_in = 1'b0; tag_push_in = 1'b1; split_in = 1'b0;
            st_in = ST_T_HDR;
         end
         ST_DONE: begin
            st_in = ST_IDLE;
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy = (st_ff != ST_IDLE);
      rsp_valid = (st_ff == ST_DONE);
   end

   assign rsp_result_addr = res_ff;
   assign rsp_status      = status_ff;
   assign rsp_grow_count  = grows_ff;
   assign rsp_split_count = splits_ff;
   assign rsp_merge_count = merges_ff;

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_ALIGN) ? {28'd0, align_ff} : 32'd0;

   // heap RAM, one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we && !mem_addr[OFF_W-1]) heap_mem[mem_addr[WADDR_W+2:3]] <= mem_wd;
      mem_q_ff <= heap_mem[mem_addr[WADDR_W+2:3]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         align_ff <= 4'd4;
         brk_ff <= '0;
         grows_ff <= '0; splits_ff <= '0; merges_ff <= '0;
         for (int i = 0; i < SIZE_CLASSES; i++) head_ff[i] <= NULL_LINK;
      end else begin
         st_ff <= st_in;
         brk_ff <= brk_in;
         grows_ff <= grows_in; splits_ff <= splits_in; merges_ff <= merges_in;
         if (head_we) head_ff[cls_ff] <= head_wd;
         if (cfg_wr && csr_paddr[2] == REG_ALIGN && brk_ff == '0) align_ff <= csr_pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      cls_ff <= cls_in; first_ff <= first_in; total_ff <= total_in;
      cur_ff <= cur_in; prev_ff <= prev_in; h_ff <= h_in; len_ff <= len_in; n_ff <= n_in;
      tag_at_ff <= tag_at_in; tag_sz_ff <= tag_sz_in; left_ff <= left_in;
      tag_used_ff <= tag_used_in; tag_push_ff <= tag_push_in; split_ff <= split_in;
      hdr_ff <= hdr_in; base_ff <= base_in; size_ff <= size_in;
      target_ff <= target_in; add_ff <= add_in; phase_ff <= phase_in; found_ff <= found_in;
      res_ff <= res_in; status_ff <= status_in;
   end

   `SFHA_ASSERT_NOW(a_strobe_busy, clock, reset, rsp_valid, busy)
   `SFHA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `SFHA_ASSERT_NOW(a_addr_zero, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_result_addr == 16'd0)
   `SFHA_ASSERT_NOW(a_brk_bound, clock, reset, 1'b1, brk_ff <= OFF_W'(HEAP_BYTES))

endmodule

FILE: test/segregated_fit_heap_allocator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segregated_fit_heap_allocator_unit_tb
// Drives allocate and free commands with random gaps and predicts every
// result with a behavioral copy of the heap. The alignment register is set
// before the first allocation, and a late write is checked to have no effect.
// ----------------------------------------------------------------------------
module segregated_fit_heap_allocator_unit_tb;
   import sfha_pkg::*;

   localparam int unsigned NO_LINK = 32'hFFFF_FFFF;
   localparam int unsigned HBYTES  = HEAP_WORDS * 8;
   localparam int          LIMIT   = 3_000_000;
   localparam logic [2:0]  ALIGN_ADDR = 3'(REG_ALIGN) << 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_cmd = CMD_ALLOC;
   logic [15:0] req_request_bytes = '0;
   logic [15:0] req_payload_addr = '0;
   logic        rsp_valid;
   logic [15:0] rsp_result_addr;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_grow_count, rsp_split_count, rsp_merge_count;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   segregated_fit_heap_allocator_unit i_dut (.*);

   always #6 clock = ~clock;

   typedef struct {
      logic [15:0] addr;
      logic [1:0]  status;
      logic [31:0] grows, splits, merges;
   } outcome_type;

   typedef struct {
      logic        cmd;
      logic [15:0] nbytes;
      logic [15:0] addr;
      int          ref_row;   // free the address returned by this row
      bit          typed;
      logic [1:0]  t_status;
   } step_row_type;

   // heap image and allocator state
   logic [63:0]  heap_img[HEAP_WORDS];
   bit           heap_wr[HEAP_WORDS];
   int unsigned  heads[SIZE_CLASSES];
   int unsigned  brk, n_grow, n_split, n_merge;
   logic [3:0]   align_reg;
   logic [15:0]  live[$];

   outcome_type  pending_q[$];
   int           errors = 0;
   int           cycles = 0;
   int           burst  = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int unsigned a_bytes();
      int unsigned lg;
      lg = align_reg;
      if (lg < 3) lg = 3;
      if (lg > 8) lg = 8;
      return 1 << lg;
   endfunction

   function automatic logic [63:0] rd(input int unsigned at);
      return ((at >> 3) < HEAP_WORDS) ? heap_img[at >> 3] : 64'd0;
   endfunction

   function automatic void wput(input int unsigned at, input logic [63:0] v);
      if ((at >> 3) < HEAP_WORDS) begin
         heap_img[at >> 3] = v;
         heap_wr[at >> 3] = 1'b1;
      end
   endfunction

   function automatic int unsigned blk_size(input int unsigned hdr);
      logic [63:0] s;
      s = rd(hdr) & ~64'd1;
      return (s > HBYTES) ? HBYTES : int'(s);
   endfunction

   function automatic int unsigned cls(input int unsigned nb);
      for (int i = 0; i < SIZE_CLASSES - 1; i++)
         if (nb <= (BASE_CLASS_BYTES << i)) return i;
      return SIZE_CLASSES - 1;
   endfunction

   function automatic int unsigned link_of(input int unsigned hdr);
      logic [63:0] v;
      v = rd(hdr + a_bytes());
      return (v >= HBYTES) ? NO_LINK : int'(v);
   endfunction

   function automatic void relink(input int unsigned c, input int unsigned prev,
                                  input int unsigned nx);
      if (prev == NO_LINK) heads[c] = nx;
      else wput(prev + a_bytes(), (nx == NO_LINK) ? '1 : 64'(nx));
   endfunction

   function automatic void push_free(input int unsigned hdr);
      int unsigned c;
      c = cls(blk_size(hdr));
      wput(hdr + a_bytes(), (heads[c] == NO_LINK) ? '1 : 64'(heads[c]));
      heads[c] = hdr;
   endfunction

   function automatic void unlink_free(input int unsigned hdr);
      int unsigned c, prev, cur;
      c = cls(blk_size(hdr));
      prev = NO_LINK;
      cur = heads[c];
      for (int n = 0; cur != NO_LINK && n < HEAP_WORDS; n++) begin
         if (cur == hdr) begin
            relink(c, prev, link_of(cur));
            return;
         end
         prev = cur;
         cur = link_of(cur);
      end
   endfunction

   function automatic int unsigned first_fit(input int unsigned c, input int unsigned need);
      int unsigned prev, cur;
      prev = NO_LINK;
      cur = heads[c];
      for (int n = 0; cur != NO_LINK && n < HEAP_WORDS; n++) begin
         if (need <= blk_size(cur)) begin
            relink(c, prev, link_of(cur));
            return cur;
         end
         prev = cur;
         cur = link_of(cur);
      end
      return NO_LINK;
   endfunction

   function automatic void tag(input int unsigned hdr, input int unsigned nb, input bit used);
      wput(hdr, 64'(nb) | 64'(used));
      wput(hdr + nb - TAG_BYTES, 64'(nb));
   endfunction

   function automatic int unsigned heap_alloc(input int unsigned req);
      int unsigned a, minb, total, sc, h, len, left;
      a = a_bytes();
      minb = a + 16;
      if (req == 0) return NO_LINK;
      total = (req + a + TAG_BYTES + (a - 1)) & ~(a - 1);
      if (total < minb) total = minb;
      sc = cls(total);
      h = first_fit(sc, total);
      for (int unsigned i = sc + 1; i < SIZE_CLASSES && h == NO_LINK; i++) begin
         if (i == SIZE_CLASSES - 1) h = first_fit(i, total);
         else begin
            h = heads[i];
            if (h != NO_LINK) heads[i] = link_of(h);
         end
      end
      if (h != NO_LINK) begin
         len = blk_size(h);
         left = (len > total) ? len - total : 0;
         if (left >= minb) begin
            tag(h, total, 1);
            tag(h + total, left, 0);
            push_free(h + total);
            n_split++;
         end else tag(h, len, 1);
         return h + a;
      end
      if (total > HBYTES - brk) return NO_LINK;
      h = brk;
      brk += total;
      n_grow++;
      tag(h, total, 1);
      return h + a;
   endfunction

   function automatic logic [1:0] heap_free(input int unsigned addr);
      int unsigned a, minb, hdr, sz, base, nx, ph;
      logic [63:0] v, nv, ns, ps, pv;
      a = a_bytes();
      minb = a + 16;
      if (addr == 0) return STATUS_OK;
      if (addr < a || (addr & (a - 1)) != 0) return STATUS_BAD;
      hdr = addr - a;
      if (hdr >= brk) return STATUS_BAD;
      v = rd(hdr);
      if (v[0] == 1'b0) return STATUS_BAD;
      v &= ~64'd1;
      if (v < minb || (v & (a - 1)) != 0 || v > 64'(brk - hdr)) return STATUS_BAD;
      sz = int'(v);
      base = hdr;
      nx = hdr + sz;
      if (nx < brk) begin
         nv = rd(nx);
         ns = nv & ~64'd1;
         if (nv[0] == 1'b0 && ns != 0 && ns <= 64'(brk - nx)) begin
            unlink_free(nx);
            sz += int'(ns);
            n_merge++;
         end
      end
      if (hdr > 0) begin
         ps = rd(hdr - TAG_BYTES) & ~64'd1;
         if (ps != 0 && ps <= 64'(hdr)) begin
            ph = hdr - int'(ps);
            pv = rd(ph);
            if (pv[0] == 1'b0) begin
               unlink_free(ph);
               base = ph;
               sz += int'(ps);
               n_merge++;
            end
         end
      end
      tag(base, sz, 0);
      push_free(base);
      return STATUS_OK;
   endfunction

   // Executes one accepted transaction on the image and returns its result.
   function automatic outcome_type apply_cmd(input logic cmd, input logic [15:0] nbytes,
                                             input logic [15:0] addr);
      outcome_type o;
      int unsigned p;
      int idx[$];
      o.addr = '0;
      if (cmd == CMD_ALLOC) begin
         p = heap_alloc(nbytes);
         if (p == NO_LINK) o.status = STATUS_NULL;
         else begin
            o.status = STATUS_OK;
            o.addr = p[15:0];
            live.push_back(p[15:0]);
         end
      end else begin
         o.status = heap_free(addr);
         if (o.status == STATUS_OK && addr != 0) begin
            idx = live.find_first_index(x) with (x == addr);
            if (idx.size() != 0) live.delete(idx[0]);
         end
      end
      o.grows = n_grow;
      o.splits = n_split;
      o.merges = n_merge;
      return o;
   endfunction

   // True when freeing addr reads only written words and cannot corrupt the heap.
   function automatic bit free_is_safe(input logic [15:0] addr);
      int unsigned a, hdr;
      int idx[$];
      a = a_bytes();
      if (addr == 0 || addr < a || (addr & (a - 1)) != 0) return 1;
      hdr = addr - a;
      if (hdr >= brk) return 1;
      if (!heap_wr[hdr >> 3]) return 0;
      if (heap_img[hdr >> 3][0] == 1'b0) return 1;
      idx = live.find_first_index(x) with (x == addr);
      return idx.size() != 0;
   endfunction

   task automatic send(input logic cmd, input logic [15:0] nbytes, input logic [15:0] addr,
                       input bit typed, input logic [1:0] t_status,
                       output logic [15:0] got_addr);
      int gap;
      outcome_type o;
      if (burst > 0) begin
         gap = 0;
         burst--;
      end else if ($urandom_range(0, 29) == 0) begin
         gap = 0;
         burst = $urandom_range(10, 30);
      end else if ($urandom_range(0, 9) < 8) gap = $urandom_range(0, 2);
      else gap = $urandom_range(5, 40);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_cmd = cmd;
      req_request_bytes = nbytes;
      req_payload_addr = addr;
      do @(posedge clock); while (busy);
      o = apply_cmd(cmd, nbytes, addr);
      got_addr = o.addr;
      if (typed) begin
         o.addr = '0;
         o.status = t_status;
      end
      pending_q.push_back(o);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      start = 1'b0;
      while (pending_q.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [31:0] val);
      csr_psel = 1'b1;
      csr_pwrite = wr;
      csr_paddr = ALIGN_ADDR;
      csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (wr) begin
         if (brk == 0) align_reg = val[3:0];
      end else if (csr_prdata !== {28'd0, align_reg})
         report("align_log2 readback", csr_prdata, {28'd0, align_reg});
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (pending_q.size() == 0) report("unexpected result", 32'(rsp_status), '0);
         else begin
            if (rsp_result_addr !== pending_q[0].addr)
               report("result_addr", 32'(rsp_result_addr), 32'(pending_q[0].addr));
            if (rsp_status !== pending_q[0].status)
               report("status", 32'(rsp_status), 32'(pending_q[0].status));
            if (rsp_grow_count !== pending_q[0].grows)
               report("grow_count", rsp_grow_count, pending_q[0].grows);
            if (rsp_split_count !== pending_q[0].splits)
               report("split_count", rsp_split_count, pending_q[0].splits);
            if (rsp_merge_count !== pending_q[0].merges)
               report("merge_count", rsp_merge_count, pending_q[0].merges);
            void'(pending_q.pop_front());
         end
      end
   end

   initial begin
      step_row_type rows[$];
      logic [15:0]  row_addr[$];
      logic [15:0]  got, addr, nbytes;
      int           pick;

      foreach (heads[i]) heads[i] = NO_LINK;
      foreach (heap_wr[i]) begin
         heap_wr[i] = 1'b0;
         heap_img[i] = '0;
      end
      brk = 0;
      n_grow = 0;
      n_split = 0;
      n_merge = 0;
      align_reg = 4'd4;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // alignment is settable only until the first allocation
      csr_access(1'b0, '0);
      csr_access(1'b1, 32'd0);
      csr_access(1'b0, '0);
      csr_access(1'b1, 32'hFFFF_FFFF);
      csr_access(1'b0, '0);
      csr_access(1'b1, $urandom_range(0, 15));
      csr_access(1'b0, '0);

      rows = '{
         '{CMD_ALLOC, 16'd0,     16'd0,     -1, 1, STATUS_NULL},
         '{CMD_FREE,  16'd0,     16'd0,     -1, 1, STATUS_OK},
         '{CMD_FREE,  16'd0,     16'd1,     -1, 1, STATUS_BAD},
         '{CMD_FREE,  16'd0,     16'hFFFF,  -1, 1, STATUS_BAD},
         '{CMD_FREE,  16'd0,     16'hFF00,  -1, 1, STATUS_BAD},   // past the break
         '{CMD_ALLOC, 16'hFFFF,  16'd0,     -1, 1, STATUS_NULL},  // out of memory
         '{CMD_ALLOC, 16'd1,     16'd0,     -1, 0, STATUS_OK},
         '{CMD_ALLOC, 16'd100,   16'd0,     -1, 0, STATUS_OK},
         '{CMD_ALLOC, 16'd24,    16'd0,     -1, 0, STATUS_OK},
         '{CMD_ALLOC, 16'd300,   16'd0,     -1, 0, STATUS_OK},
         '{CMD_ALLOC, 16'd2000,  16'd0,     -1, 0, STATUS_OK},
         '{CMD_ALLOC, 16'd40,    16'd0,     -1, 0, STATUS_OK},
         '{CMD_FREE,  16'd0,     16'd0,      7, 0, STATUS_OK},
         '{CMD_FREE,  16'd0,     16'd0,      8, 0, STATUS_OK},    // merges backward
         '{CMD_FREE,  16'd0,     16'd0,      7, 1, STATUS_BAD},   // double free
         '{CMD_ALLOC, 16'd50,    16'd0,     -1, 0, STATUS_OK},
         '{CMD_FREE,  16'd0,     16'd0,     10, 0, STATUS_OK},
         '{CMD_ALLOC, 16'd1000,  16'd0,     -1, 0, STATUS_OK},
         '{CMD_FREE,  16'd0,     16'd0,      6, 0, STATUS_OK},    // block at heap base
         '{CMD_FREE,  16'd0,     16'd0,      9, 0, STATUS_OK},
         '{CMD_ALLOC, 16'd20000, 16'd0,     -1, 0, STATUS_OK},
         '{CMD_ALLOC, 16'd40000, 16'd0,     -1, 0, STATUS_OK},
         '{CMD_FREE,  16'd0,     16'd0,     11, 0, STATUS_OK},
         '{CMD_FREE,  16'd0,     16'd0,     15, 0, STATUS_OK},
         '{CMD_FREE,  16'd0,     16'd0,     20, 0, STATUS_OK}
      };
      foreach (rows[i]) begin
         addr = (rows[i].ref_row >= 0) ? row_addr[rows[i].ref_row] : rows[i].addr;
         if (rows[i].cmd == CMD_FREE && !free_is_safe(addr)) addr = 16'd1;
         send(rows[i].cmd, rows[i].nbytes, addr, rows[i].typed, rows[i].t_status, got);
         row_addr.push_back(got);
      end

      // heap is in use now: this write must be ignored
      wait_idle();
      csr_access(1'b1, 32'(~align_reg));
      csr_access(1'b0, '0);

      for (int n = 0; n < 450; n++) begin
         if (n == 200) wait_idle();
         pick = $urandom_range(0, 99);
         if (pick < 50 || (pick < 85 && live.size() == 0)) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) nbytes = 16'd0;
            else if (pick < 6) nbytes = 16'($urandom);
            else if (pick < 16) nbytes = 16'($urandom_range(1, 8000));
            else nbytes = 16'($urandom_range(1, 600));
            send(CMD_ALLOC, nbytes, 16'($urandom), 0, STATUS_OK, got);
         end else if (pick < 85) begin
            addr = live[$urandom_range(0, live.size() - 1)];
            send(CMD_FREE, 16'($urandom), addr, 0, STATUS_OK, got);
         end else begin
            addr = 16'($urandom);
            if (!free_is_safe(addr)) addr = addr | 16'd1;
            send(CMD_FREE, 16'($urandom), addr, 0, STATUS_OK, got);
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
